/* sv/tcg_pkg.sv */
// Package for the thermal charge guard: field widths, register indexes and reset values.
// Used by the top level and its testbench; depends on nothing.
`default_nettype none
package tcg_pkg;

  localparam int unsigned PctW     = 7;
  localparam int unsigned TempW    = 15;
  localparam int unsigned PauseW   = 13;
  localparam int unsigned ResumeW  = 12;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned CfgIdxW  = 3;

  typedef logic [PctW-1:0]     pct_t;
  typedef logic signed [TempW-1:0] temp_t;
  typedef logic [PauseW-1:0]   pause_temp_t;
  typedef logic [ResumeW-1:0]  resume_temp_t;
  typedef logic [CfgDataW-1:0] cfg_data_t;
  typedef logic [CfgIdxW-1:0]  cfg_idx_t;

  localparam cfg_idx_t CFG_MODE_ENABLE   = 3'd0;
  localparam cfg_idx_t CFG_GUARD_ENABLE  = 3'd1;
  localparam cfg_idx_t CFG_FLOOR_PCT     = 3'd2;
  localparam cfg_idx_t CFG_CEILING_PCT   = 3'd3;
  localparam cfg_idx_t CFG_PAUSE_TEMP    = 3'd4;
  localparam cfg_idx_t CFG_RESUME_TEMP   = 3'd5;

  localparam pct_t         FLOOR_PCT_RST   = 7'd70;
  localparam pct_t         CEILING_PCT_RST = 7'd80;
  localparam pause_temp_t  PAUSE_TEMP_RST  = 13'd4000;
  localparam resume_temp_t RESUME_TEMP_RST = 12'd3700;

endpackage
`default_nettype wire

/* sv/thermal_charge_guard_unit.sv */
// Thermal charge guard top level: input register, flag update logic and result register.
// Depends on tcg_pkg.
`default_nettype none
// One telemetry tick goes in per transfer and one result comes out per tick. A tick is
// captured in an input register and evaluated into the result register when that register
// is free or its result is being taken; a waiting result holds it. A new tick can be
// taken in every cycle while results are taken. While a result waits, the input register
// takes one more tick and then holds the input off until the result moves on.
// Configuration registers must be written only while no tick is in flight.
// The paused, inhibit, ownership and verified flags are reset to zero.
module thermal_charge_guard_unit (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_we,
  input  wire tcg_pkg::cfg_idx_t    cfg_index,
  input  wire tcg_pkg::cfg_data_t   cfg_wdata,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire logic                 in_battery_valid,
  input  wire logic                 in_temp_valid,
  input  wire tcg_pkg::temp_t       in_temperature_centi,
  input  wire tcg_pkg::pct_t        in_charge_pct,
  input  wire logic                 in_external_power,
  input  wire logic                 in_ctl_path,
  input  wire logic                 in_write_ok,
  input  wire logic                 in_reported_valid,
  input  wire logic                 in_reported_inhibit,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic                      out_paused,
  output logic                      out_inhibit,
  output logic                      out_owns,
  output logic                      out_control_error,
  output logic                      out_verified,
  output logic                      out_hold_display,
  output logic                      out_ui_allowed
);
  import tcg_pkg::*;

  logic         mode_en_r, guard_en_r;
  pct_t         floor_r, ceiling_r;
  pause_temp_t  pause_temp_r;
  resume_temp_t resume_temp_r;

  logic pause_r, inhibit_r, owner_r, verified_r;
  logic pause_nxt, inhibit_nxt, owner_nxt, verified_nxt;

  logic  in_vld_r;
  logic  batt_r, tvld_r, ext_r, ctl_r, wok_r, rep_vld_r, rep_inh_r;
  temp_t temp_r;
  pct_t  pct_r;

  logic  err_nxt;
  logic  advance, compute;
  logic  inh_obs, ver_obs, want, wr_req, wr_val;

  assign advance  = !out_valid || out_ready;
  assign compute  = in_vld_r && advance;
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_en_r     <= 1'b0;
      guard_en_r    <= 1'b0;
      floor_r       <= FLOOR_PCT_RST;
      ceiling_r     <= CEILING_PCT_RST;
      pause_temp_r  <= PAUSE_TEMP_RST;
      resume_temp_r <= RESUME_TEMP_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE_ENABLE:  mode_en_r     <= cfg_wdata[0];
        CFG_GUARD_ENABLE: guard_en_r    <= cfg_wdata[0];
        CFG_FLOOR_PCT:    floor_r       <= cfg_wdata[PctW-1:0];
        CFG_CEILING_PCT:  ceiling_r     <= cfg_wdata[PctW-1:0];
        CFG_PAUSE_TEMP:   pause_temp_r  <= cfg_wdata[PauseW-1:0];
        CFG_RESUME_TEMP:  resume_temp_r <= cfg_wdata[ResumeW-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      batt_r    <= in_battery_valid;
      tvld_r    <= in_temp_valid;
      temp_r    <= in_temperature_centi;
      pct_r     <= in_charge_pct;
      ext_r     <= in_external_power;
      ctl_r     <= in_ctl_path;
      wok_r     <= in_write_ok;
      rep_vld_r <= in_reported_valid;
      rep_inh_r <= in_reported_inhibit;
    end
  end

  always_comb begin
    inh_obs = rep_vld_r ? rep_inh_r : inhibit_r;
    ver_obs = rep_vld_r || verified_r;

    if (!mode_en_r) begin
      pause_nxt = 1'b0;
    end else if (!batt_r || !tvld_r) begin
      pause_nxt = 1'b1;
    end else if (!pause_r && (temp_r >= $signed({2'b00, pause_temp_r}))) begin
      pause_nxt = 1'b1;
    end else if (pause_r && (temp_r <= $signed({3'b000, resume_temp_r}))) begin
      pause_nxt = 1'b0;
    end else begin
      pause_nxt = pause_r;
    end

    if (pause_nxt || (pct_r >= ceiling_r)) begin
      want = 1'b1;
    end else if (pct_r <= floor_r) begin
      want = 1'b0;
    end else begin
      want = inh_obs;
    end

    if (!mode_en_r || !guard_en_r) begin
      wr_req = owner_r;
      wr_val = 1'b0;
    end else if (batt_r && ext_r && ctl_r) begin
      wr_req = (want != inh_obs) || (want && !owner_r);
      wr_val = want;
    end else begin
      wr_req = 1'b0;
      wr_val = 1'b0;
    end

    if (wr_req && wok_r) begin
      inhibit_nxt  = wr_val;
      owner_nxt    = wr_val;
      verified_nxt = 1'b1;
    end else begin
      inhibit_nxt  = inh_obs;
      owner_nxt    = owner_r;
      verified_nxt = ver_obs;
    end
    err_nxt = wr_req && !wok_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pause_r    <= 1'b0;
      inhibit_r  <= 1'b0;
      owner_r    <= 1'b0;
      verified_r <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (compute) begin
        pause_r    <= pause_nxt;
        inhibit_r  <= inhibit_nxt;
        owner_r    <= owner_nxt;
        verified_r <= verified_nxt;
      end
      if (advance) begin
        out_valid <= in_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (compute) begin
      out_paused        <= pause_nxt;
      out_inhibit       <= inhibit_nxt;
      out_owns          <= owner_nxt;
      out_control_error <= err_nxt;
      out_verified      <= verified_nxt;
      out_hold_display  <= mode_en_r && !pause_nxt;
      out_ui_allowed    <= !mode_en_r || !pause_nxt;
    end
  end

endmodule
`default_nettype wire

/* sv/tcg_checker.sv */
// Port checker for the thermal charge guard, bound to the top level.
// Depends on thermal_charge_guard_unit.
`default_nettype none
module tcg_checker (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic               out_paused,
  input wire logic               out_inhibit,
  input wire logic               out_owns,
  input wire logic               out_control_error,
  input wire logic               out_verified,
  input wire logic               out_hold_display,
  input wire logic               out_ui_allowed
);

  logic [6:0] out_bits;
  assign out_bits = {out_paused, out_inhibit, out_owns, out_control_error,
                     out_verified, out_hold_display, out_ui_allowed};

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_bits))
    else $error("Stalled result changed before its transfer.");

  a_ui_vs_pause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_ui_allowed == !out_paused))
    else $error("UI permission disagrees with the pause flag.");

  a_hold_needs_ui: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hold_display |-> out_ui_allowed && !out_paused)
    else $error("Display hold requested while paused.");

  a_owner_verified: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_owns |-> out_verified)
    else $error("Ownership reported without a verified inhibit state.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_valid |-> in_ready)
    else $error("Input held off while no result is waiting.");

endmodule

bind thermal_charge_guard_unit tcg_checker u_tcg_checker (.*);
`default_nettype wire

/* tb/thermal_charge_guard_unit_tb.sv */
// Self-checking testbench for thermal_charge_guard_unit: directed ticks, then random
// telemetry walks under changing settings, checked against an in-bench flag predictor.
// Depends on tcg_pkg and the thermal_charge_guard_unit RTL.
`default_nettype none
module thermal_charge_guard_unit_tb;
  import tcg_pkg::*;

  typedef struct {
    logic  battery_valid;
    logic  temp_valid;
    temp_t temperature_centi;
    pct_t  charge_pct;
    logic  external_power;
    logic  ctl_path;
    logic  write_ok;
    logic  reported_valid;
    logic  reported_inhibit;
  } tick_t;

  typedef struct packed {
    logic paused;
    logic inhibit;
    logic owns;
    logic control_error;
    logic verified;
    logic hold_display;
    logic ui_allowed;
  } guard_flags_t;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      cfg_we = 1'b0;
  cfg_idx_t  cfg_index = CFG_MODE_ENABLE;
  cfg_data_t cfg_wdata = '0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  logic      in_battery_valid = 1'b0;
  logic      in_temp_valid = 1'b0;
  temp_t     in_temperature_centi = '0;
  pct_t      in_charge_pct = '0;
  logic      in_external_power = 1'b0;
  logic      in_ctl_path = 1'b0;
  logic      in_write_ok = 1'b0;
  logic      in_reported_valid = 1'b0;
  logic      in_reported_inhibit = 1'b0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  logic      out_paused;
  logic      out_inhibit;
  logic      out_owns;
  logic      out_control_error;
  logic      out_verified;
  logic      out_hold_display;
  logic      out_ui_allowed;

  thermal_charge_guard_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_battery_valid    (in_battery_valid),
    .in_temp_valid       (in_temp_valid),
    .in_temperature_centi(in_temperature_centi),
    .in_charge_pct       (in_charge_pct),
    .in_external_power   (in_external_power),
    .in_ctl_path         (in_ctl_path),
    .in_write_ok         (in_write_ok),
    .in_reported_valid   (in_reported_valid),
    .in_reported_inhibit (in_reported_inhibit),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_paused          (out_paused),
    .out_inhibit         (out_inhibit),
    .out_owns            (out_owns),
    .out_control_error   (out_control_error),
    .out_verified        (out_verified),
    .out_hold_display    (out_hold_display),
    .out_ui_allowed      (out_ui_allowed)
  );

  // Mirror of the configuration registers and of the guard state.
  logic         mode_en    = 1'b0;
  logic         guard_en   = 1'b0;
  pct_t         floor_cfg  = FLOOR_PCT_RST;
  pct_t         ceil_cfg   = CEILING_PCT_RST;
  pause_temp_t  pause_cfg  = PAUSE_TEMP_RST;
  resume_temp_t resume_cfg = RESUME_TEMP_RST;
  logic         paused_st   = 1'b0;
  logic         inhibit_st  = 1'b0;
  logic         owner_st    = 1'b0;
  logic         verified_st = 1'b0;

  tick_t        ticks_pending[$];
  guard_flags_t flags_due[$];
  tick_t        cur_tick;
  string        flag_names[7] = '{"paused", "inhibit", "owns", "control_error",
                                  "verified", "hold_display", "ui_allowed"};

  int  gap_left = 0;
  int  stall_left = 0;
  bit  tx_burst = 1'b0;
  bit  rx_burst = 1'b0;
  bit  rx_hold = 1'b0;
  int  n_accepted = 0;
  int  n_results = 0;
  int  n_paused_seen = 0;
  int  n_refused_seen = 0;
  int  n_settings = 0;
  int  n_errors = 0;
  int  walk_temp = 3800;
  int  walk_pct = 75;
  int  temp_dir = 1;
  int  pct_dir = 1;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic logic write_inhibit(logic value, logic accepted);
    if (!accepted) return 1'b1;
    inhibit_st  = value;
    verified_st = 1'b1;
    owner_st    = value;
    return 1'b0;
  endfunction

  function automatic guard_flags_t next_guard_flags(tick_t t);
    guard_flags_t r;
    logic         want;
    logic         err;
    int           temp_c;
    temp_c = $signed(t.temperature_centi);
    err = 1'b0;
    if (t.reported_valid) begin
      inhibit_st  = t.reported_inhibit;
      verified_st = 1'b1;
    end
    if (!mode_en) begin
      paused_st = 1'b0;
    end else if (!t.battery_valid || !t.temp_valid) begin
      paused_st = 1'b1;
    end else if (!paused_st && temp_c >= int'(pause_cfg)) begin
      paused_st = 1'b1;
    end else if (paused_st && temp_c <= int'(resume_cfg)) begin
      paused_st = 1'b0;
    end
    if (!mode_en || !guard_en) begin
      if (owner_st) err = write_inhibit(1'b0, t.write_ok);
    end else if (t.battery_valid && t.external_power && t.ctl_path) begin
      want = inhibit_st;
      if (paused_st || t.charge_pct >= ceil_cfg) want = 1'b1;
      else if (t.charge_pct <= floor_cfg) want = 1'b0;
      if (want != inhibit_st || (want && !owner_st)) err = write_inhibit(want, t.write_ok);
    end
    r.paused        = paused_st;
    r.inhibit       = inhibit_st;
    r.owns          = owner_st;
    r.control_error = err;
    r.verified      = verified_st;
    r.hold_display  = mode_en && !paused_st;
    r.ui_allowed    = !mode_en || !paused_st;
    return r;
  endfunction

  // Sender: one tick per transfer, with a random wait drawn after each transfer.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        flags_due.push_back(next_guard_flags(cur_tick));
        n_accepted++;
        gap_left = tx_burst ? 0 : $urandom_range(0, 13);
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (ticks_pending.size() != 0) begin
          cur_tick = ticks_pending.pop_front();
          in_valid             <= 1'b1;
          in_battery_valid     <= cur_tick.battery_valid;
          in_temp_valid        <= cur_tick.temp_valid;
          in_temperature_centi <= cur_tick.temperature_centi;
          in_charge_pct        <= cur_tick.charge_pct;
          in_external_power    <= cur_tick.external_power;
          in_ctl_path          <= cur_tick.ctl_path;
          in_write_ok          <= cur_tick.write_ok;
          in_reported_valid    <= cur_tick.reported_valid;
          in_reported_inhibit  <= cur_tick.reported_inhibit;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result transfer against the oldest predicted flags.
  always @(posedge clk) begin
    guard_flags_t got;
    guard_flags_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        got = {out_paused, out_inhibit, out_owns, out_control_error, out_verified,
               out_hold_display, out_ui_allowed};
        n_results++;
        if (got.paused) n_paused_seen++;
        if (got.control_error) n_refused_seen++;
        if (flags_due.size() == 0) begin
          n_errors++;
          $display("%0t: result %b arrived with nothing expected", $time, got);
        end else begin
          want = flags_due.pop_front();
          for (int i = 0; i < 7; i++) begin
            if (got[6-i] !== want[6-i]) begin
              n_errors++;
              $display("%0t: %s expected %0b, got %0b", $time, flag_names[i],
                       want[6-i], got[6-i]);
            end
          end
        end
        stall_left = rx_burst ? 0 : $urandom_range(0, 13);
      end
      if (rx_hold) begin
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // A long receiver hold-off while ticks keep coming, so the input side backs up.
  initial begin
    wait (n_accepted >= 650);
    @(negedge clk);
    rx_hold = 1'b1;
    repeat (300) @(negedge clk);
    rx_hold = 1'b0;
  end

  initial begin
    #5000000;
    $display("Run timed out with %0d results still expected", flags_due.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic void queue_tick(bit bv, bit tv, int temp, int pct, bit ext, bit ctl,
                                     bit wok, bit rv, bit ri);
    tick_t t;
    t.battery_valid     = bv;
    t.temp_valid        = tv;
    t.temperature_centi = temp_t'(temp);
    t.charge_pct        = pct_t'(pct);
    t.external_power    = ext;
    t.ctl_path          = ctl;
    t.write_ok          = wok;
    t.reported_valid    = rv;
    t.reported_inhibit  = ri;
    ticks_pending.push_back(t);
  endfunction

  // Mostly a slow walk of temperature and charge across the thresholds, sometimes noise.
  function automatic void queue_random_tick();
    int lo;
    int hi;
    int step;
    if ($urandom_range(0, 9) < 7) begin
      lo = (int'(resume_cfg) < int'(pause_cfg) ? int'(resume_cfg) : int'(pause_cfg)) - 500;
      hi = (int'(resume_cfg) < int'(pause_cfg) ? int'(pause_cfg) : int'(resume_cfg)) + 500;
      step = $urandom_range(0, 120);
      walk_temp += temp_dir * step;
      if (walk_temp >= hi) temp_dir = -1;
      else if (walk_temp <= lo) temp_dir = 1;
      else if ($urandom_range(0, 19) == 0) temp_dir = -temp_dir;
      lo = (floor_cfg < ceil_cfg ? int'(floor_cfg) : int'(ceil_cfg)) - 8;
      hi = (floor_cfg < ceil_cfg ? int'(ceil_cfg) : int'(floor_cfg)) + 8;
      if (lo < 0) lo = 0;
      if (hi > 100) hi = 100;
      step = $urandom_range(0, 3);
      walk_pct += pct_dir * step;
      if (walk_pct >= hi) begin
        walk_pct = hi;
        pct_dir = -1;
      end else if (walk_pct <= lo) begin
        walk_pct = lo;
        pct_dir = 1;
      end
      queue_tick($urandom_range(0, 19) != 0, $urandom_range(0, 19) != 0, walk_temp,
                 walk_pct, $urandom_range(0, 9) != 0, $urandom_range(0, 9) != 0,
                 $urandom_range(0, 4) != 0, $urandom_range(0, 3) == 0,
                 $urandom_range(0, 1));
    end else begin
      queue_tick($urandom_range(0, 1), $urandom_range(0, 1),
                 ($urandom_range(0, 9) == 0) ? int'($urandom)
                                             : int'($urandom_range(0, 16000)) - 4000,
                 ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                             : $urandom_range(0, 100),
                 $urandom_range(0, 1), $urandom_range(0, 1), $urandom_range(0, 1),
                 $urandom_range(0, 1), $urandom_range(0, 1));
    end
  endfunction

  task automatic wait_idle();
    do @(negedge clk);
    while (ticks_pending.size() != 0 || in_valid || flags_due.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, cfg_data_t val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_MODE_ENABLE:  mode_en    = val[0];
      CFG_GUARD_ENABLE: guard_en   = val[0];
      CFG_FLOOR_PCT:    floor_cfg  = pct_t'(val);
      CFG_CEILING_PCT:  ceil_cfg   = pct_t'(val);
      CFG_PAUSE_TEMP:   pause_cfg  = pause_temp_t'(val);
      CFG_RESUME_TEMP:  resume_cfg = resume_temp_t'(val);
      default: ;
    endcase
  endtask

  task automatic apply_settings(bit mode, bit guard, int floor_pct, int ceil_pct,
                                int pause_t, int resume_t);
    wait_idle();
    write_reg(CFG_MODE_ENABLE, cfg_data_t'(mode));
    write_reg(CFG_GUARD_ENABLE, cfg_data_t'(guard));
    write_reg(CFG_FLOOR_PCT, cfg_data_t'(floor_pct));
    write_reg(CFG_CEILING_PCT, cfg_data_t'(ceil_pct));
    write_reg(CFG_PAUSE_TEMP, cfg_data_t'(pause_t));
    write_reg(CFG_RESUME_TEMP, cfg_data_t'(resume_t));
    @(posedge clk);
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    apply_settings(1, 1, 70, 80, 4000, 3700);
    queue_tick(1, 1, 2500, 50, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 2500, 80, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 2500, 75, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 2500, 70, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 3999, 50, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 4000, 50, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 3701, 50, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 3700, 50, 1, 1, 1, 0, 0);
    queue_tick(0, 1, 2500, 50, 1, 1, 1, 0, 0);
    queue_tick(1, 0, 2500, 85, 1, 1, 0, 0, 0);
    queue_tick(1, 1, 2500, 75, 1, 1, 1, 1, 1);
    queue_tick(1, 1, 2500, 75, 1, 1, 1, 1, 0);
    queue_tick(1, 1, -4000, 0, 1, 1, 0, 0, 0);
    queue_tick(1, 1, 12000, 100, 0, 1, 1, 0, 0);
    queue_tick(1, 1, -16384, 127, 1, 0, 1, 0, 0);
    queue_tick(1, 1, 16383, 127, 1, 1, 1, 0, 0);
    // Guard off while owning the inhibit: a release is tried even without a control path.
    apply_settings(1, 0, 70, 80, 4000, 3700);
    queue_tick(1, 1, 2500, 50, 1, 1, 0, 0, 0);
    queue_tick(1, 1, 2500, 50, 0, 0, 1, 0, 0);
    apply_settings(1, 1, 70, 80, 4000, 3700);
    queue_tick(1, 1, 2500, 90, 1, 1, 1, 0, 0);
    apply_settings(0, 0, 70, 80, 4000, 3700);
    queue_tick(0, 0, 5000, 90, 1, 1, 0, 1, 1);
    queue_tick(0, 0, 5000, 90, 1, 1, 1, 0, 0);
    queue_tick(1, 1, 5000, 90, 1, 1, 1, 0, 0);

    for (int phase = 0; phase < 8; phase++) begin
      wait_idle();
      tx_burst = ($urandom_range(0, 2) == 0);
      rx_burst = ($urandom_range(0, 2) == 0);
      case (phase)
        0: apply_settings(1, 1, 40, 45, 2700, 2500);
        1: apply_settings(1, 1, 79, 90, 4500, 3900);
        5: apply_settings(1, 1, $urandom_range(0, 127), $urandom_range(0, 127),
                          $urandom_range(0, 8191), $urandom_range(0, 4095));
        default: apply_settings($urandom_range(0, 7) != 0, $urandom_range(0, 7) != 0,
                                $urandom_range(40, 79), $urandom_range(45, 90),
                                $urandom_range(2700, 4500), $urandom_range(2500, 3900));
      endcase
      walk_temp = int'(resume_cfg);
      walk_pct  = int'(floor_cfg) > 100 ? 100 : int'(floor_cfg);
      repeat (250) queue_random_tick();
    end

    wait_idle();
    repeat (10) @(posedge clk);
    if (flags_due.size() != 0) begin
      n_errors++;
      $display("%0t: %0d expected results never arrived", $time, flags_due.size());
    end
    $display("Checked %0d ticks under %0d register settings: %0d paused results,",
             n_results, n_settings, n_paused_seen);
    $display("%0d refused inhibit writes, %0d mismatches.", n_refused_seen, n_errors);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
`default_nettype wire
